[rtl/webacc_pkg.sv]
// shared types and constants of the wavefield energy beam accumulator
`default_nettype none

package webacc_pkg;

    localparam int KINDS     = 8;
    localparam int ACC_W     = 48;
    localparam int SAMPLE_W  = 32;
    localparam int SPACING_W = 32;
    localparam int FRAC_W    = 16;
    localparam int CONTRIB_W = 51;
    localparam int MODE_W    = 2;
    localparam int COORD_W   = 6;
    localparam int GRID_CMP_W = 13;
    localparam int CFG_IDX_W = 1;

    localparam logic [ACC_W-1:0]     ACC_MAX       = {ACC_W{1'b1}};
    localparam logic [KINDS-1:0]     MASK_RESET    = 8'hFF;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 32'h0001_0000;

    // beam kinds, bit order of the enable mask
    localparam int KIND_VX   = 0;
    localparam int KIND_VZ   = 1;
    localparam int KIND_P    = 2;
    localparam int KIND_TZZ  = 3;
    localparam int KIND_TXX  = 4;
    localparam int KIND_TXZ  = 5;
    localparam int KIND_DIV  = 6;
    localparam int KIND_ROT  = 7;

    localparam logic [CFG_IDX_W-1:0] REG_KIND_MASK   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_SPACING = 1'd1;

    typedef enum logic [MODE_W-1:0] {
        MODE_ACC   = 2'd0,
        MODE_READ  = 2'd1,
        MODE_CLEAR = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef struct packed {
        logic  valid;
        t_mode mode;
        logic  in_grid;
    } t_ctl;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] vx_here;
        logic signed [SAMPLE_W-1:0] vx_right;
        logic signed [SAMPLE_W-1:0] vx_right_down;
        logic signed [SAMPLE_W-1:0] vz_here;
        logic signed [SAMPLE_W-1:0] vz_down;
        logic signed [SAMPLE_W-1:0] vz_right_down;
        logic signed [SAMPLE_W-1:0] tzz_here;
        logic signed [SAMPLE_W-1:0] txx_here;
        logic signed [SAMPLE_W-1:0] txz_right_down;
    } t_samples;

    typedef logic [KINDS-1:0][ACC_W-1:0]     t_row;
    typedef logic [KINDS-1:0][CONTRIB_W-1:0] t_contrib;

endpackage

`default_nettype wire

[rtl/webacc_contrib.sv]
// three-stage datapath: magnitudes, spacing products, rounded contributions
`default_nettype none

module webacc_contrib
    import webacc_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire t_samples             i_samples,
    input  wire logic [SPACING_W-1:0] i_inverse_spacing,
    output t_contrib                  o_contrib
);

    localparam int DIFF_W = SAMPLE_W + 2;
    localparam int PROD_W = DIFF_W + FRAC_W;
    localparam logic [CONTRIB_W-1:0] ROUND_HALF = CONTRIB_W'(1) << (FRAC_W - 1);

    function automatic logic [SAMPLE_W-1:0] abs_sample(input logic signed [SAMPLE_W-1:0] v);
        abs_sample = v[SAMPLE_W-1] ? SAMPLE_W'(-v) : SAMPLE_W'(v);
    endfunction

    function automatic logic [DIFF_W-1:0] abs_diff(input logic signed [DIFF_W-1:0] v);
        abs_diff = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    endfunction

    function automatic logic [CONTRIB_W-1:0] round_scale(input logic [PROD_W-1:0] hi,
                                                         input logic [PROD_W-1:0] lo);
        logic [CONTRIB_W-1:0] lo_r;
        lo_r = (CONTRIB_W'(lo) + ROUND_HALF) >> FRAC_W;
        round_scale = CONTRIB_W'(hi) + lo_r;
    endfunction

    logic signed [DIFF_W-1:0] w_div;
    logic signed [DIFF_W-1:0] w_rot;

    logic [SAMPLE_W-1:0] r2_vx, r2_vz, r2_tzz, r2_txx, r2_txz;
    logic [DIFF_W-1:0]   r2_div, r2_rot;
    logic [SAMPLE_W-1:0] r3_vx, r3_vz, r3_tzz, r3_txx, r3_txz;
    logic [PROD_W-1:0]   r3_div_hi, r3_div_lo, r3_rot_hi, r3_rot_lo;
    t_contrib            r_contrib;

    // differences are exact in 34 bits
    assign w_div = (DIFF_W'(i_samples.vx_right) - DIFF_W'(i_samples.vx_here))
                 + (DIFF_W'(i_samples.vz_down)  - DIFF_W'(i_samples.vz_here));
    assign w_rot = (DIFF_W'(i_samples.vx_right_down) - DIFF_W'(i_samples.vx_right))
                 - (DIFF_W'(i_samples.vz_right_down) - DIFF_W'(i_samples.vz_down));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r2_vx  <= abs_sample(i_samples.vx_right);
            r2_vz  <= abs_sample(i_samples.vz_down);
            r2_tzz <= abs_sample(i_samples.tzz_here);
            r2_txx <= abs_sample(i_samples.txx_here);
            r2_txz <= abs_sample(i_samples.txz_right_down);
            r2_div <= abs_diff(w_div);
            r2_rot <= abs_diff(w_rot);

            r3_vx  <= r2_vx;
            r3_vz  <= r2_vz;
            r3_tzz <= r2_tzz;
            r3_txx <= r2_txx;
            r3_txz <= r2_txz;
            // integer and fraction halves of the spacing, 34x16 each
            r3_div_hi <= PROD_W'(r2_div) * PROD_W'(i_inverse_spacing[SPACING_W-1:FRAC_W]);
            r3_div_lo <= PROD_W'(r2_div) * PROD_W'(i_inverse_spacing[FRAC_W-1:0]);
            r3_rot_hi <= PROD_W'(r2_rot) * PROD_W'(i_inverse_spacing[SPACING_W-1:FRAC_W]);
            r3_rot_lo <= PROD_W'(r2_rot) * PROD_W'(i_inverse_spacing[FRAC_W-1:0]);

            r_contrib[KIND_VX]  <= CONTRIB_W'(r3_vx);
            r_contrib[KIND_VZ]  <= CONTRIB_W'(r3_vz);
            r_contrib[KIND_P]   <= CONTRIB_W'(r3_tzz);
            r_contrib[KIND_TZZ] <= CONTRIB_W'(r3_tzz);
            r_contrib[KIND_TXX] <= CONTRIB_W'(r3_txx);
            r_contrib[KIND_TXZ] <= CONTRIB_W'(r3_txz);
            r_contrib[KIND_DIV] <= round_scale(r3_div_hi, r3_div_lo);
            r_contrib[KIND_ROT] <= round_scale(r3_rot_hi, r3_rot_lo);
        end
    end

    assign o_contrib = r_contrib;

endmodule

`default_nettype wire

[rtl/webacc_store.sv]
// per-cell accumulator memory with reset clearing pass and write forwarding
`default_nettype none

module webacc_store
    import webacc_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_en,
    input  wire logic [AW-1:0] i_rd_cell,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_cell,
    input  wire t_row          i_wr_row,
    output t_row               o_row,
    output logic [AW-1:0]      o_cell,
    output logic               o_clearing
);

    t_row mem [DEPTH];

    logic          r_clearing;
    logic [AW-1:0] r_clr_addr;

    t_row          r_rd_raw;
    logic          r_fwd_hit;
    t_row          r_fwd_row;
    t_row          r_row3;
    t_row          r_row4;
    logic [AW-1:0] r_cell2, r_cell3, r_cell4;

    t_row          w_row2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clearing) begin
            r_clr_addr <= r_clr_addr + AW'(1);
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            mem[i_wr_cell] <= i_wr_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rd_raw <= mem[i_rd_cell];
        end
    end

    // the read above returns old data on a same-cell write, so keep the write
    assign w_row2 = r_fwd_hit ? r_fwd_row : r_rd_raw;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fwd_hit <= i_wr_en && (i_wr_cell == i_rd_cell);
            r_fwd_row <= i_wr_row;
            r_cell2   <= i_rd_cell;
            r_cell3   <= r_cell2;
            r_cell4   <= r_cell3;
            r_row3    <= (i_wr_en && (i_wr_cell == r_cell2)) ? i_wr_row : w_row2;
            r_row4    <= (i_wr_en && (i_wr_cell == r_cell3)) ? i_wr_row : r_row3;
        end
    end

    assign o_row      = r_row4;
    assign o_cell     = r_cell4;
    assign o_clearing = r_clearing;

endmodule

`default_nettype wire

[rtl/wavefield_energy_beam_accumulator_core.sv]
// top level of the wavefield energy beam accumulator
//
//  channel | valid      | ready       | payload
//  --------+------------+-------------+---------------------------------------
//  input   | i_in_valid | o_in_ready  | i_mode, i_column, i_row, 9 samples
//  result  | o_out_valid| i_out_ready | o_sum_* (8 accumulators, read mode)
//  config  | i_cfg_valid| o_cfg_ready | i_cfg_index, i_cfg_data
//
// one transaction per cycle unless a result is held or clearing runs; a read
// result passes the input register, three datapath stages and the output
// register; after reset a clearing pass writes every cell (COLUMNS*ROWS,
// 4096 by default) with o_in_ready low; config writes are taken meanwhile;
// a held result stalls the whole pipeline; read-modify-write hazards on a
// cell are resolved by forwarding the write-back row into later stages
`default_nettype none

module wavefield_energy_beam_accumulator_core
    import webacc_pkg::*;
#(
    parameter int COLUMNS = 64,
    parameter int ROWS    = 64
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,

    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire logic [MODE_W-1:0]           i_mode,
    input  wire logic [COORD_W-1:0]          i_column,
    input  wire logic [COORD_W-1:0]          i_row,
    input  wire logic signed [SAMPLE_W-1:0]  i_vx_here,
    input  wire logic signed [SAMPLE_W-1:0]  i_vx_right,
    input  wire logic signed [SAMPLE_W-1:0]  i_vx_right_down,
    input  wire logic signed [SAMPLE_W-1:0]  i_vz_here,
    input  wire logic signed [SAMPLE_W-1:0]  i_vz_down,
    input  wire logic signed [SAMPLE_W-1:0]  i_vz_right_down,
    input  wire logic signed [SAMPLE_W-1:0]  i_tzz_here,
    input  wire logic signed [SAMPLE_W-1:0]  i_txx_here,
    input  wire logic signed [SAMPLE_W-1:0]  i_txz_right_down,

    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output logic [ACC_W-1:0]                 o_sum_vx,
    output logic [ACC_W-1:0]                 o_sum_vz,
    output logic [ACC_W-1:0]                 o_sum_pressure,
    output logic [ACC_W-1:0]                 o_sum_tzz,
    output logic [ACC_W-1:0]                 o_sum_txx,
    output logic [ACC_W-1:0]                 o_sum_txz,
    output logic [ACC_W-1:0]                 o_sum_divergence,
    output logic [ACC_W-1:0]                 o_sum_rotation,

    input  wire logic                        i_cfg_valid,
    output logic                             o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]        i_cfg_index,
    input  wire logic [SPACING_W-1:0]        i_cfg_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam int PW    = AW + COORD_W + 1;

    logic [KINDS-1:0]     r_kind_enable_mask;
    logic [SPACING_W-1:0] r_inverse_spacing;

    t_ctl          r_p1_ctl, r_p2_ctl, r_p3_ctl, r_p4_ctl;
    t_samples      r_p1_samples;
    logic [AW-1:0] r_p1_cell;

    logic          r_out_valid;
    t_row          r_sum;

    logic          w_advance;
    logic          w_accept;
    logic          w_inside;
    logic [PW-1:0] w_cell_full;
    logic [AW-1:0] w_cell;
    logic          w_clearing;
    t_row          w_row;
    logic [AW-1:0] w_p4_cell;
    t_contrib      w_contrib;
    t_row          w_wr_row;
    logic          w_wr_en;
    t_samples      w_samples;

    assign w_advance  = !r_out_valid || i_out_ready;
    assign o_in_ready = w_advance && !w_clearing;
    assign w_accept   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    assign w_inside = (GRID_CMP_W'(i_column) < GRID_CMP_W'(COLUMNS))
                   && (GRID_CMP_W'(i_row) < GRID_CMP_W'(ROWS));
    assign w_cell_full = PW'(i_column) * PW'(ROWS) + PW'(i_row);
    assign w_cell = w_inside ? w_cell_full[AW-1:0] : '0;

    assign w_samples.vx_here        = i_vx_here;
    assign w_samples.vx_right       = i_vx_right;
    assign w_samples.vx_right_down  = i_vx_right_down;
    assign w_samples.vz_here        = i_vz_here;
    assign w_samples.vz_down        = i_vz_down;
    assign w_samples.vz_right_down  = i_vz_right_down;
    assign w_samples.tzz_here       = i_tzz_here;
    assign w_samples.txx_here       = i_txx_here;
    assign w_samples.txz_right_down = i_txz_right_down;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind_enable_mask <= MASK_RESET;
            r_inverse_spacing  <= SPACING_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_KIND_MASK:   r_kind_enable_mask <= i_cfg_data[KINDS-1:0];
                REG_INV_SPACING: r_inverse_spacing  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_ctl <= '0;
            r_p2_ctl <= '0;
            r_p3_ctl <= '0;
            r_p4_ctl <= '0;
        end else if (w_advance) begin
            r_p1_ctl.valid   <= w_accept;
            r_p1_ctl.mode    <= t_mode'(i_mode);
            r_p1_ctl.in_grid <= w_inside;
            r_p2_ctl <= r_p1_ctl;
            r_p3_ctl <= r_p2_ctl;
            r_p4_ctl <= r_p3_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_p1_samples <= w_samples;
            r_p1_cell    <= w_cell;
        end
    end

    webacc_contrib u_contrib (
        .i_clk             (i_clk),
        .i_en              (w_advance),
        .i_samples         (r_p1_samples),
        .i_inverse_spacing (r_inverse_spacing),
        .o_contrib         (w_contrib)
    );

    webacc_store #(
        .DEPTH (CELLS),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_advance),
        .i_rd_cell  (r_p1_cell),
        .i_wr_en    (w_wr_en),
        .i_wr_cell  (w_p4_cell),
        .i_wr_row   (w_wr_row),
        .o_row      (w_row),
        .o_cell     (w_p4_cell),
        .o_clearing (w_clearing)
    );

    // accumulate enabled kinds with saturation, or clear the whole row
    always_comb begin
        logic [ACC_W+4-1:0] sum;
        w_wr_row = '0;
        for (int k = 0; k < KINDS; k++) begin
            sum = (ACC_W + 4)'(w_row[k]) + (ACC_W + 4)'(w_contrib[k]);
            if (r_p4_ctl.mode == MODE_ACC) begin
                if (!r_kind_enable_mask[k]) begin
                    w_wr_row[k] = w_row[k];
                end else if (|sum[ACC_W+4-1:ACC_W]) begin
                    w_wr_row[k] = ACC_MAX;
                end else begin
                    w_wr_row[k] = sum[ACC_W-1:0];
                end
            end
        end
    end

    assign w_wr_en = w_advance && r_p4_ctl.valid && r_p4_ctl.in_grid
                  && ((r_p4_ctl.mode == MODE_ACC) || (r_p4_ctl.mode == MODE_CLEAR));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= r_p4_ctl.valid && (r_p4_ctl.mode == MODE_READ);
        end
    end

    // cells outside the window read back as zero
    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_sum <= r_p4_ctl.in_grid ? w_row : '0;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_sum_vx         = r_sum[KIND_VX];
    assign o_sum_vz         = r_sum[KIND_VZ];
    assign o_sum_pressure   = r_sum[KIND_P];
    assign o_sum_tzz        = r_sum[KIND_TZZ];
    assign o_sum_txx        = r_sum[KIND_TXX];
    assign o_sum_txz        = r_sum[KIND_TXZ];
    assign o_sum_divergence = r_sum[KIND_DIV];
    assign o_sum_rotation   = r_sum[KIND_ROT];

endmodule

`default_nettype wire

[test/tb_wavefield_energy_beam_accumulator_core.sv]
// self-checking testbench for the wavefield energy beam accumulator core
`timescale 1ns / 100ps

module tb_wavefield_energy_beam_accumulator_core;
    import webacc_pkg::*;

    localparam int GRID_COLS    = 64;
    localparam int GRID_ROWS    = 64;
    localparam int GRID_CELLS   = GRID_COLS * GRID_ROWS;
    localparam int DRAIN_CYCLES = 16;
    localparam int LONG_HOLD    = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_ITEMS  = 250;

    localparam logic [31:0] S_MIN = 32'h8000_0000;
    localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
    localparam logic [ACC_W-1:0] H31 = 48'h0000_8000_0000;

    typedef struct packed {
        t_mode      mode;
        logic [5:0] col;
        logic [5:0] row;
        t_samples   smp;
    } t_cell;

    typedef logic [0:KINDS-1][ACC_W-1:0] t_sums;

    typedef struct packed {
        logic        is_cfg;
        logic [31:0] mask_word;
        logic [31:0] spacing;
        t_cell       item;
        logic        typed;
        t_sums       sums;
    } t_plan_row;

    localparam t_samples NO_SMP  = '{default: 32'd0};
    localparam t_samples MIN_SMP = '{default: S_MIN};
    localparam t_samples MAX_SMP = '{default: S_MAX};
    // divergence saturates at once, rotation after two passes at full spacing
    localparam t_samples SAT_SMP =
        '{S_MIN, S_MAX, S_MIN, S_MIN, S_MAX, S_MAX, 32'd0, 32'd0, 32'd0};
    localparam t_samples MIX_SMP = '{32'd100, 32'hFFFF_FF06, 32'h0012_3456,
        32'hFFFF_0000, 32'd7, S_MIN, 32'hDEAD_BEEF, 32'd1, S_MAX};
    // an odd divergence against a spacing just above one half, so rounding shows
    localparam t_samples RND_SMP =
        '{32'd1, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0, 32'd9, S_MIN, 32'd3};
    localparam t_cell NO_CELL = '{MODE_ACC, 6'd0, 6'd0, NO_SMP};
    localparam t_sums NO_SUMS = '{default: 48'd0};

    localparam int PLAN_LEN = 24;
    localparam t_plan_row PLAN [PLAN_LEN] = '{
        '{0, 0, 0, '{MODE_READ,  6'd0,  6'd0,  NO_SMP},  1, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd63, 6'd63, MIN_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd63, 6'd63, NO_SMP},  1,
            '{H31, H31, H31, H31, H31, H31, 48'd0, 48'd0}},
        '{0, 0, 0, '{MODE_ACC,   6'd0,  6'd63, SAT_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd0,  6'd63, NO_SMP},  0, NO_SUMS},
        '{1, 32'h0000_00FF, 32'hFFFF_FFFF, NO_CELL, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd63, 6'd0,  SAT_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd63, 6'd0,  SAT_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd63, 6'd0,  NO_SMP},  1,
            '{48'hFFFF_FFFE, 48'hFFFF_FFFE, 48'd0, 48'd0, 48'd0, 48'd0,
              ACC_MAX, ACC_MAX}},
        '{0, 0, 0, '{MODE_ACC,   6'd63, 6'd0,  SAT_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd63, 6'd0,  NO_SMP},  0, NO_SUMS},
        '{0, 0, 0, '{MODE_CLEAR, 6'd63, 6'd0,  MAX_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd63, 6'd0,  NO_SMP},  1, NO_SUMS},
        '{1, 32'hFFFF_FF00, 32'h0000_0000, NO_CELL, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd63, 6'd0,  MAX_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd63, 6'd0,  NO_SMP},  1, NO_SUMS},
        '{0, 0, 0, '{MODE_NONE,  6'd0,  6'd0,  MAX_SMP}, 0, NO_SUMS},
        '{1, 32'h0000_00FF, 32'h0000_0000, NO_CELL, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd0,  6'd0,  MIX_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd0,  6'd0,  NO_SMP},  0, NO_SUMS},
        '{1, 32'h0000_00A5, 32'h0000_8001, NO_CELL, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_ACC,   6'd0,  6'd0,  RND_SMP}, 0, NO_SUMS},
        '{0, 0, 0, '{MODE_READ,  6'd0,  6'd0,  NO_SMP},  0, NO_SUMS},
        '{1, 32'h0000_00FF, 32'h0001_0000, NO_CELL, 0, NO_SUMS}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    t_cell in_cell = '0;
    logic out_ready = 1'b0;
    logic cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SPACING_W-1:0] cfg_data = '0;

    logic o_in_ready, o_out_valid, o_cfg_ready;
    logic [ACC_W-1:0] o_sum_vx, o_sum_vz, o_sum_pressure, o_sum_tzz;
    logic [ACC_W-1:0] o_sum_txx, o_sum_txz, o_sum_divergence, o_sum_rotation;

    // predictor state
    logic [ACC_W-1:0] beam_acc [GRID_CELLS][KINDS] = '{default: '{default: '0}};
    logic [KINDS-1:0] kind_mask = MASK_RESET;
    logic [SPACING_W-1:0] inv_spacing = SPACING_RESET;

    t_sums read_sums_due [$];
    string kind_name [KINDS] = '{"vx", "vz", "pressure", "tzz", "txx", "txz",
                                 "divergence", "rotation"};
    int error_count = 0;
    int cycle_count = 0;
    int gap_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    int holds_served = 0;

    wavefield_energy_beam_accumulator_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_mode           (in_cell.mode),
        .i_column         (in_cell.col),
        .i_row            (in_cell.row),
        .i_vx_here        (in_cell.smp.vx_here),
        .i_vx_right       (in_cell.smp.vx_right),
        .i_vx_right_down  (in_cell.smp.vx_right_down),
        .i_vz_here        (in_cell.smp.vz_here),
        .i_vz_down        (in_cell.smp.vz_down),
        .i_vz_right_down  (in_cell.smp.vz_right_down),
        .i_tzz_here       (in_cell.smp.tzz_here),
        .i_txx_here       (in_cell.smp.txx_here),
        .i_txz_right_down (in_cell.smp.txz_right_down),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_sum_vx         (o_sum_vx),
        .o_sum_vz         (o_sum_vz),
        .o_sum_pressure   (o_sum_pressure),
        .o_sum_tzz        (o_sum_tzz),
        .o_sum_txx        (o_sum_txx),
        .o_sum_txz        (o_sum_txz),
        .o_sum_divergence (o_sum_divergence),
        .o_sum_rotation   (o_sum_rotation),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        $display("%0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic logic [63:0] magnitude(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    // magnitude times Q16.16 spacing, rounded half up to one lsb
    function automatic logic [63:0] spacing_scaled(input logic [63:0] m);
        logic [63:0] whole, frac;
        whole = m * {48'd0, inv_spacing[31:16]};
        frac  = m * {48'd0, inv_spacing[15:0]};
        return whole + ((frac + 64'h8000) >> 16);
    endfunction

    // updates the beam store for one transaction; returns 1 with the sums on a read
    function automatic bit apply_to_beams(input t_cell c, output t_sums sums);
        logic [63:0] gain [KINDS];
        logic [63:0] total;
        longint div_d, rot_d;
        bit in_window;
        int idx;
        sums = '0;
        in_window = (int'(c.col) < GRID_COLS) && (int'(c.row) < GRID_ROWS);
        idx = int'(c.col) * GRID_ROWS + int'(c.row);
        if (c.mode == MODE_READ) begin
            if (in_window)
                for (int k = 0; k < KINDS; k++) sums[k] = beam_acc[idx][k];
            return 1'b1;
        end
        if (!in_window || c.mode == MODE_NONE)
            return 1'b0;
        if (c.mode == MODE_CLEAR) begin
            for (int k = 0; k < KINDS; k++) beam_acc[idx][k] = '0;
            return 1'b0;
        end
        div_d = longint'($signed(c.smp.vx_right)) - longint'($signed(c.smp.vx_here))
              + longint'($signed(c.smp.vz_down)) - longint'($signed(c.smp.vz_here));
        rot_d = longint'($signed(c.smp.vx_right_down)) - longint'($signed(c.smp.vx_right))
              - longint'($signed(c.smp.vz_right_down)) + longint'($signed(c.smp.vz_down));
        gain[KIND_VX]  = magnitude($signed(c.smp.vx_right));
        gain[KIND_VZ]  = magnitude($signed(c.smp.vz_down));
        gain[KIND_P]   = magnitude($signed(c.smp.tzz_here));
        gain[KIND_TZZ] = magnitude($signed(c.smp.tzz_here));
        gain[KIND_TXX] = magnitude($signed(c.smp.txx_here));
        gain[KIND_TXZ] = magnitude($signed(c.smp.txz_right_down));
        gain[KIND_DIV] = spacing_scaled(magnitude(div_d));
        gain[KIND_ROT] = spacing_scaled(magnitude(rot_d));
        for (int k = 0; k < KINDS; k++) begin
            if (kind_mask[k]) begin
                total = {16'd0, beam_acc[idx][k]} + gain[k];
                beam_acc[idx][k] = (total > {16'd0, ACC_MAX}) ? ACC_MAX : total[ACC_W-1:0];
            end
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] pick_sample();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) return S_MIN;
        if (r < 20) return S_MAX;
        if (r < 35) return 32'($urandom_range(2000)) - 32'd1000;
        return $urandom;
    endfunction

    // mostly a few hot cells so back-to-back updates of one cell are frequent
    function automatic t_cell random_cell();
        t_cell c;
        int unsigned r;
        r = $urandom_range(99);
        c.mode = (r < 58) ? MODE_ACC : (r < 88) ? MODE_READ :
                 (r < 94) ? MODE_CLEAR : MODE_NONE;
        if ($urandom_range(99) < 70) begin
            c.col = $urandom_range(1) ? 6'd63 : 6'd1;
            c.row = $urandom_range(1) ? 6'd0 : 6'd62;
        end else begin
            c.col = 6'($urandom);
            c.row = 6'($urandom);
        end
        for (int k = 0; k < 9; k++) c.smp[k*32 +: 32] = pick_sample();
        return c;
    endfunction

    task automatic offer_cell(input t_cell c, input bit typed, input t_sums typed_sums);
        t_sums sums;
        if ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < gap_pct);
        end
        in_valid <= 1'b1;
        in_cell  <= c;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        if (apply_to_beams(c, sums))
            read_sums_due.push_back(typed ? typed_sums : sums);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (read_sums_due.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // both registers in a row with valid held high, only once the block is idle
    task automatic set_config(input logic [31:0] mask_word, input logic [31:0] spacing_word);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= REG_KIND_MASK;
        cfg_data  <= mask_word;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        kind_mask = mask_word[KINDS-1:0];
        cfg_index <= REG_INV_SPACING;
        cfg_data  <= spacing_word;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        inv_spacing = spacing_word;
        cfg_valid <= 1'b0;
    endtask

    initial begin
        forever begin
            @(posedge clk);
            if (hold_requests != holds_served) begin
                holds_served = hold_requests;
                out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            out_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        t_sums got, want;
        if (rst_n && o_out_valid && out_ready) begin
            got = '{o_sum_vx, o_sum_vz, o_sum_pressure, o_sum_tzz, o_sum_txx,
                    o_sum_txz, o_sum_divergence, o_sum_rotation};
            if (read_sums_due.size() == 0) begin
                flag_error("result transaction with no read pending");
            end else begin
                want = read_sums_due.pop_front();
                for (int k = 0; k < KINDS; k++)
                    if (got[k] !== want[k])
                        flag_error($sformatf("sum_%s got %h want %h",
                                             kind_name[k], got[k], want[k]));
            end
        end
    end

    initial begin
        t_cell c;
        int phase_gap [4]   = '{0, 74, 0, 30};
        int phase_stall [4] = '{0, 0, 74, 30};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < PLAN_LEN; i++) begin
            if (PLAN[i].is_cfg)
                set_config(PLAN[i].mask_word, PLAN[i].spacing);
            else
                offer_cell(PLAN[i].item, PLAN[i].typed, PLAN[i].sums);
        end

        for (int p = 0; p < 4; p++) begin
            case (p)
                0: set_config({24'($urandom), 8'hFF}, $urandom_range(32'h0004_0000));
                1: set_config($urandom, $urandom);
                2: set_config(32'h0000_00FF, 32'hFFFF_FFFF);
                default: set_config($urandom, $urandom_range(255));
            endcase
            gap_pct   = phase_gap[p];
            stall_pct = phase_stall[p];
            if (p == 0) begin
                // receiver holds off while reads pile up behind the stalled output
                hold_requests++;
                repeat (40) begin
                    c = random_cell();
                    c.mode = MODE_READ;
                    offer_cell(c, 1'b0, NO_SUMS);
                end
            end
            repeat (PHASE_ITEMS) offer_cell(random_cell(), 1'b0, NO_SUMS);
        end

        settle();
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
